// ===== rtl/core/ear_pkg.sv =====
// ----------------------------------------------------------------------------
// ear_pkg: shared types and constants for the encoder angle reverse lookup
// Holds field widths, item opcodes, the control word and status layouts and
// the microcode ROM that drives the lookup datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ear_pkg;

  localparam int ANGLE_W               = 16;
  localparam int ENTRY_INDEX_W         = 6;
  localparam int DEFAULT_TABLE_ENTRIES = 64;
  localparam int DEFAULT_SEARCH_LIMIT  = 20;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    STEP_IDLE    = 4'd0,
    STEP_GUESS   = 4'd1,
    STEP_RDCUR   = 4'd2,
    STEP_CHKLIM  = 4'd3,
    STEP_CHKLO   = 4'd4,
    STEP_RDNXT   = 4'd5,
    STEP_CHKHI   = 4'd6,
    STEP_RIGHT   = 4'd7,
    STEP_LEFT    = 4'd8,
    STEP_BAIL    = 4'd9,
    STEP_MUL     = 4'd10,
    STEP_DIV     = 4'd11,
    STEP_DIVWAIT = 4'd12,
    STEP_SUM     = 4'd13,
    STEP_EMIT    = 4'd14
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_NO_START = 3'd1,
    COND_AT_LIMIT = 3'd2,
    COND_BELOW    = 3'd3,
    COND_BRACKET  = 3'd4,
    COND_DIV_BUSY = 3'd5,
    COND_OUT_BUSY = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_CUR  = 2'd1,
    RD_NXT  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    cond_t   cond;
    step_t   jmp;
    step_t   nxt;
    logic    in_ready;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ld_guess;
    logic    ld_x1;
    logic    ld_x2;
    logic    step_r;
    logic    step_l;
    logic    ld_prod;
    logic    div_start;
    logic    ld_match;
    logic    ld_bail;
    logic    emit;
  } uword_t;

  typedef struct packed {
    logic start;
    logic at_limit;
    logic below;
    logic bracket;
    logic div_busy;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w        = '0;
    w.cond   = COND_ALWAYS;
    w.rd_sel = RD_ZERO;
    unique case (s)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.rd_en    = 1'b1;
        w.rd_sel   = RD_ZERO;
        w.cond     = COND_NO_START;
        w.jmp      = STEP_IDLE;
        w.nxt      = STEP_GUESS;
      end
      STEP_GUESS: begin
        w.ld_guess = 1'b1;
        w.jmp      = STEP_RDCUR;
        w.nxt      = STEP_RDCUR;
      end
      STEP_RDCUR: begin
        w.rd_en  = 1'b1;
        w.rd_sel = RD_CUR;
        w.jmp    = STEP_CHKLIM;
        w.nxt    = STEP_CHKLIM;
      end
      STEP_CHKLIM: begin
        w.ld_x1 = 1'b1;
        w.cond  = COND_AT_LIMIT;
        w.jmp   = STEP_BAIL;
        w.nxt   = STEP_CHKLO;
      end
      STEP_CHKLO: begin
        w.cond = COND_BELOW;
        w.jmp  = STEP_LEFT;
        w.nxt  = STEP_RDNXT;
      end
      STEP_RDNXT: begin
        w.rd_en  = 1'b1;
        w.rd_sel = RD_NXT;
        w.jmp    = STEP_CHKHI;
        w.nxt    = STEP_CHKHI;
      end
      STEP_CHKHI: begin
        w.ld_x2 = 1'b1;
        w.cond  = COND_BRACKET;
        w.jmp   = STEP_MUL;
        w.nxt   = STEP_RIGHT;
      end
      STEP_RIGHT: begin
        w.step_r = 1'b1;
        w.jmp    = STEP_CHKLIM;
        w.nxt    = STEP_CHKLIM;
      end
      STEP_LEFT: begin
        w.step_l = 1'b1;
        w.jmp    = STEP_RDCUR;
        w.nxt    = STEP_RDCUR;
      end
      STEP_BAIL: begin
        w.ld_bail = 1'b1;
        w.jmp     = STEP_EMIT;
        w.nxt     = STEP_EMIT;
      end
      STEP_MUL: begin
        w.ld_prod = 1'b1;
        w.jmp     = STEP_DIV;
        w.nxt     = STEP_DIV;
      end
      STEP_DIV: begin
        w.div_start = 1'b1;
        w.jmp       = STEP_DIVWAIT;
        w.nxt       = STEP_DIVWAIT;
      end
      STEP_DIVWAIT: begin
        w.cond = COND_DIV_BUSY;
        w.jmp  = STEP_DIVWAIT;
        w.nxt  = STEP_SUM;
      end
      STEP_SUM: begin
        w.ld_match = 1'b1;
        w.jmp      = STEP_EMIT;
        w.nxt      = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.jmp  = STEP_EMIT;
        w.nxt  = STEP_IDLE;
      end
      default: begin
        w.jmp = STEP_IDLE;
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/ear_in_if.sv =====
// ----------------------------------------------------------------------------
// ear_in_if: input item channel
// Valid/ready channel carrying table writes and angle lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ear_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [ear_pkg::ENTRY_INDEX_W-1:0]   entry_index;
  logic [ear_pkg::ANGLE_W-1:0]         entry_value;
  logic [ear_pkg::ANGLE_W-1:0]         encoder_angle;

  modport source (
    output valid, operation, entry_index, entry_value, encoder_angle,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_value, encoder_angle,
    output ready
  );
endinterface

// ===== rtl/core/ear_out_if.sv =====
// ----------------------------------------------------------------------------
// ear_out_if: result channel
// Valid/ready channel carrying the corrected angle and match flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ear_out_if;
  logic                        valid;
  logic                        ready;
  logic [ear_pkg::ANGLE_W-1:0] corrected_angle;
  logic                        matched;

  modport source (
    output valid, corrected_angle, matched,
    input  ready
  );
  modport sink (
    input  valid, corrected_angle, matched,
    output ready
  );
endinterface

// ===== rtl/core/ear_div.sv =====
// ----------------------------------------------------------------------------
// ear_div: iterative unsigned divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle; the quotient must fit in 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ear_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2*ear_pkg::ANGLE_W-1:0] dividend,
  input  logic [ear_pkg::ANGLE_W-1:0]   divisor,
  output logic                          busy,
  output logic [ear_pkg::ANGLE_W-1:0]   quotient
);
  import ear_pkg::*;

  localparam int CNT_W = $clog2(ANGLE_W + 1);

  logic [ANGLE_W-1:0] rem_r;
  logic [ANGLE_W-1:0] quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic [ANGLE_W:0]   trial;
  logic               ge;
  logic [ANGLE_W:0]   diff;

  always_comb begin
    trial = {rem_r, quo_r[ANGLE_W-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ANGLE_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*ANGLE_W-1:ANGLE_W];
      quo_r <= dividend[ANGLE_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[ANGLE_W-1:0] : trial[ANGLE_W-1:0];
      quo_r <= {quo_r[ANGLE_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/ear_seq.sv =====
// ----------------------------------------------------------------------------
// ear_seq: microcode sequencer
// Step counter over the control ROM; each step selects a condition and
// branches to its jump target when it holds, else to its next step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ear_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ear_pkg::status_t  st,
  output ear_pkg::uword_t   uw
);
  import ear_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  always_comb begin
    uw = ucode_rom(pc_r);
    unique case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NO_START: take = !st.start;
      COND_AT_LIMIT: take = st.at_limit;
      COND_BELOW:    take = st.below;
      COND_BRACKET:  take = st.bracket;
      COND_DIV_BUSY: take = st.div_busy;
      COND_OUT_BUSY: take = st.out_busy;
      default:       take = 1'b1;
    endcase
    pc_nxt = take ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/encoder_angle_reverse_lookup.sv =====
// ----------------------------------------------------------------------------
// encoder_angle_reverse_lookup: corrected shaft angle from a raw encoder angle
// A write item (operation 1) stores one measured angle into the table and
// gives no result. A lookup item (operation 0) guesses a start entry from
// the angle, walks the table circularly until two neighbors bracket the
// angle, and interpolates between their ideal positions; after SEARCH_LIMIT
// moves without a bracket it returns the entry it stopped on with matched
// low. A lookup reads entry zero and guesses, then moves left or right one
// entry at a time, then multiplies, divides and emits; the next item is not
// taken until the result has entered the output register. The single read
// port of the table serializes the walk and the bit-serial divider sets the
// interpolation time. Inputs are taken only between lookups; a finished result
// waits in the output register while the next item is taken. Entries must be
// written before a lookup reads them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_angle_reverse_lookup #(
  parameter int TABLE_ENTRIES = ear_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int SEARCH_LIMIT  = ear_pkg::DEFAULT_SEARCH_LIMIT
) (
  input  logic     clk,
  input  logic     rst_n,
  ear_in_if.sink   in_ch,
  ear_out_if.source out_ch
);
  import ear_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int ITER_W = $clog2(SEARCH_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  uword_t  uw;
  status_t st;

  logic [ANGLE_W-1:0]   tbl_mem [TABLE_ENTRIES];
  logic [ANGLE_W-1:0]   ideal_pos [TABLE_ENTRIES];

  logic [ANGLE_W-1:0]   x_r;
  logic [ANGLE_W-1:0]   rdata_r;
  logic [ANGLE_W-1:0]   x1_r;
  logic [ANGLE_W-1:0]   x2_r;
  logic [IDX_W-1:0]     cur_r;
  logic [ITER_W-1:0]    iter_r;
  logic [2*ANGLE_W-1:0] prod_r;
  logic [ANGLE_W-1:0]   span_r;
  logic [ANGLE_W-1:0]   res_angle_r;
  logic                 res_match_r;
  logic [ANGLE_W-1:0]   out_angle_r;
  logic                 out_match_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     nxt_idx;
  logic [IDX_W-1:0]     dec_idx;
  logic [ANGLE_W-1:0]   base_diff;
  logic [31:0]          guess_full;
  logic [ANGLE_W-1:0]   below_diff;
  logic [ANGLE_W-1:0]   above;
  logic [ANGLE_W-1:0]   off;
  logic [ANGLE_W-1:0]   rise;
  logic [ANGLE_W-1:0]   span_nxt;
  logic [2*ANGLE_W-1:0] prod_nxt;
  logic                 div_busy;
  logic [ANGLE_W-1:0]   quot;
  logic                 out_busy;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_ideal
    localparam logic [31:0] POS = (32'(g) * 32'd65536) / TABLE_ENTRIES;
    assign ideal_pos[g] = POS[ANGLE_W-1:0];
  end

  ear_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw)
  );

  ear_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (uw.div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    accept   = in_ch.valid && uw.in_ready && rst_n;
    wr_en    = accept && (in_ch.operation == OP_WRITE) &&
               (32'(in_ch.entry_index) < 32'(TABLE_ENTRIES));
    wr_addr  = IDX_W'(in_ch.entry_index);
    nxt_idx  = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;
    dec_idx  = (cur_r == '0) ? LAST_IDX : cur_r - 1'b1;
    unique case (uw.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_CUR:  rd_addr = cur_r;
      RD_NXT:  rd_addr = nxt_idx;
      default: rd_addr = '0;
    endcase
    base_diff  = x_r - rdata_r;
    guess_full = (32'(base_diff) * 32'(TABLE_ENTRIES)) >> ANGLE_W;
    below_diff = x_r - x1_r;
    above      = rdata_r - x_r;
    off        = x_r - x1_r;
    rise       = ideal_pos[nxt_idx] - ideal_pos[cur_r];
    span_nxt   = x2_r - x1_r;
    prod_nxt   = 32'(off) * 32'(rise);
    out_busy   = out_valid_r && !out_ch.ready;

    st.start    = accept && (in_ch.operation == OP_LOOKUP);
    st.at_limit = iter_r == ITER_W'(SEARCH_LIMIT);
    st.below    = below_diff[ANGLE_W-1];
    st.bracket  = (above != '0) && !above[ANGLE_W-1];
    st.div_busy = div_busy;
    st.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= in_ch.entry_value;
    end
    if (uw.rd_en) begin
      rdata_r <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (st.start) begin
      x_r <= in_ch.encoder_angle;
    end
    if (uw.ld_guess) begin
      cur_r <= guess_full[IDX_W-1:0];
    end else if (uw.step_r) begin
      cur_r <= nxt_idx;
    end else if (uw.step_l) begin
      cur_r <= dec_idx;
    end
    if (uw.ld_guess) begin
      iter_r <= '0;
    end else if (uw.step_r || uw.step_l) begin
      iter_r <= iter_r + 1'b1;
    end
    if (uw.ld_x1) begin
      x1_r <= rdata_r;
    end
    if (uw.ld_x2) begin
      x2_r <= rdata_r;
    end
    if (uw.ld_prod) begin
      prod_r <= prod_nxt;
      span_r <= span_nxt;
    end
    if (uw.ld_match) begin
      res_angle_r <= (span_r == '0) ? ideal_pos[cur_r] : ideal_pos[cur_r] + quot;
      res_match_r <= 1'b1;
    end else if (uw.ld_bail) begin
      res_angle_r <= x1_r;
      res_match_r <= 1'b0;
    end
    if (uw.emit && !out_busy) begin
      out_angle_r <= res_angle_r;
      out_match_r <= res_match_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready            = uw.in_ready && rst_n;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.corrected_angle = out_angle_r;
  assign out_ch.matched         = out_match_r;

endmodule

// ===== tb/sv/tb_encoder_angle_reverse_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_encoder_angle_reverse_lookup: self-checking bench for the angle lookup
// Loads the angle table with ramps, rotated and jittered ramps, noise and
// flat contents, then walks a short directed list and a long random mix of
// writes and lookups. Each lookup is scored against a fixed result or a
// predictor on a shadow table; channels idle at random in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_encoder_angle_reverse_lookup;
  import ear_pkg::*;

  localparam int          TBL_N        = DEFAULT_TABLE_ENTRIES;
  localparam int          WALK_LIMIT   = DEFAULT_SEARCH_LIMIT;
  localparam int          SLOT         = 65536 / TBL_N;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BEATS  = 90;
  localparam int          TAIL_CYCLES  = 200;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               matched;
  } shaft_result_t;

  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_RAMP,
    FILL_FLAT
  } fill_kind_t;

  typedef struct {
    fill_kind_t          fill;
    op_t                 op;
    logic [ENTRY_INDEX_W-1:0] idx;
    logic [ANGLE_W-1:0]  val;
    logic [ANGLE_W-1:0]  ang;
    bit                  typed;
    shaft_result_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ear_in_if  in_ch ();
  ear_out_if out_ch ();

  encoder_angle_reverse_lookup u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [ANGLE_W-1:0] angle_shadow [TBL_N];
  shaft_result_t      pending_angles [$];
  dir_row_t           dir_rows [$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  bit                 send_idle_on = 1'b1;
  bit                 sink_idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_encoder_angle_reverse_lookup: FAIL");
      $finish;
    end
  end

  function automatic logic [ANGLE_W-1:0] ideal_angle(int unsigned idx);
    return ANGLE_W'((idx * 65536) / TBL_N);
  endfunction

  function automatic shaft_result_t solve_shaft_angle(input logic [ANGLE_W-1:0] x);
    shaft_result_t      r;
    logic [ANGLE_W-1:0] rel, x1, x2, gap_lo, gap_hi, span, rise, off, y1, y2;
    int unsigned        cur, nxt;
    rel = x - angle_shadow[0];
    cur = (32'(rel) * TBL_N) >> 16;
    if (cur >= TBL_N) cur = TBL_N - 1;
    for (int i = 0; i < WALK_LIMIT; i++) begin
      x1     = angle_shadow[cur];
      gap_lo = x - x1;
      if (!gap_lo[ANGLE_W-1]) begin
        nxt    = (cur == TBL_N - 1) ? 0 : cur + 1;
        x2     = angle_shadow[nxt];
        gap_hi = x2 - x;
        if (gap_hi != '0 && !gap_hi[ANGLE_W-1]) begin
          y1   = ideal_angle(cur);
          y2   = ideal_angle(nxt);
          span = x2 - x1;
          rise = y2 - y1;
          off  = x - x1;
          r.matched = 1'b1;
          if (span == '0) r.angle = y1;
          else r.angle = y1 + ANGLE_W'((32'(off) * 32'(rise)) / 32'(span));
          return r;
        end
        cur = nxt;
      end else begin
        cur = (cur == 0) ? TBL_N - 1 : cur - 1;
      end
    end
    r.angle   = angle_shadow[cur];
    r.matched = 1'b0;
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] shaped_entry(int unsigned idx,
      logic [ANGLE_W-1:0] base, int unsigned jitter, bit flat);
    int n;
    n = (jitter == 0) ? 0 : int'($urandom_range(0, 2 * jitter)) - int'(jitter);
    if (flat) return base;
    return ANGLE_W'(int'(base) + int'(idx) * SLOT + n);
  endfunction

  task automatic push_beat(input op_t op, input logic [ENTRY_INDEX_W-1:0] idx,
      input logic [ANGLE_W-1:0] val, input logic [ANGLE_W-1:0] ang,
      input bit typed, input shaft_result_t typed_res);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.entry_index   <= idx;
    in_ch.entry_value   <= val;
    in_ch.encoder_angle <= ang;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_WRITE) begin
      angle_shadow[idx] = val;
    end else if (typed) begin
      pending_angles.push_back(typed_res);
    end else begin
      pending_angles.push_back(solve_shaft_angle(ang));
    end
  endtask

  task automatic load_angle_table(input logic [ANGLE_W-1:0] base,
      input int unsigned jitter, input bit flat);
    for (int i = 0; i < TBL_N; i++)
      push_beat(OP_WRITE, ENTRY_INDEX_W'(i), shaped_entry(i, base, jitter, flat),
                ANGLE_W'($urandom), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_angles.size() != 0);
  endtask

  task automatic add_row(input fill_kind_t fill, input op_t op, input int idx,
      input int val, input int ang, input bit typed, input int res_ang,
      input bit res_m);
    dir_row_t r;
    r.fill          = fill;
    r.op            = op;
    r.idx           = ENTRY_INDEX_W'(idx);
    r.val           = ANGLE_W'(val);
    r.ang           = ANGLE_W'(ang);
    r.typed         = typed;
    r.res.angle     = ANGLE_W'(res_ang);
    r.res.matched   = res_m;
    dir_rows.push_back(r);
  endtask

  // result side
  initial begin
    int unsigned   stall;
    shaft_result_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_angles.size() == 0) begin
        $display("%0t: result beat with no lookup waiting: angle %h matched %b",
                 $time, out_ch.corrected_angle, out_ch.matched);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (out_ch.corrected_angle !== want.angle) begin
          $display("%0t: corrected_angle mismatch: expected %h, actual %h",
                   $time, want.angle, out_ch.corrected_angle);
          errors++;
        end
        if (out_ch.matched !== want.matched) begin
          $display("%0t: matched mismatch: expected %b, actual %b",
                   $time, want.matched, out_ch.matched);
          errors++;
        end
      end
    end
  end

  // stimulus side
  initial begin
    int unsigned        style, jitter;
    logic [ANGLE_W-1:0] base, ang, val;
    logic [ENTRY_INDEX_W-1:0] idx;
    bit                 flat;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_LOOKUP;
    in_ch.entry_index   <= '0;
    in_ch.entry_value   <= '0;
    in_ch.encoder_angle <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clean ramp: corrected angle equals the raw angle
    add_row(FILL_RAMP, OP_WRITE,  0, 0, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h0000, 1'b1, 16'h0000, 1'b1);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h8000, 1'b1, 16'h8000, 1'b1);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 1023, 1'b1, 1023, 1'b1);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 64512, 1'b1, 64512, 1'b1);
    // rotate entry zero so the guess lands on the last entry and brackets across the wrap
    add_row(FILL_NONE, OP_WRITE,  0, 300, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 200, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'hFFFF, 1'b0, 0, 1'b0);
    // equal neighbors: step right past the flat pair
    add_row(FILL_NONE, OP_WRITE,  10, 11 * SLOT, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 11 * SLOT, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 10300, 1'b0, 0, 1'b0);
    // raised entry: step left off the guess
    add_row(FILL_NONE, OP_WRITE,  20, 30000, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 21600, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_WRITE,  20, 20 * SLOT, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_WRITE,  10, 10 * SLOT, 0, 1'b0, 0, 1'b0);
    // flat tables: walk runs out and returns the entry value
    add_row(FILL_FLAT, OP_WRITE,  0, 16'hFFFF, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h0000, 1'b1, 16'hFFFF, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h7FFF, 1'b1, 16'hFFFF, 1'b0);
    add_row(FILL_FLAT, OP_WRITE,  0, 16'h0000, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h0000, 1'b1, 16'h0000, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h8000, 1'b1, 16'h0000, 1'b0);
    add_row(FILL_NONE, OP_WRITE,  5, 16'hAAAA, 0, 1'b0, 0, 1'b0);
    add_row(FILL_NONE, OP_LOOKUP, 0, 0, 16'h5555, 1'b0, 0, 1'b0);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].fill)
        FILL_RAMP: load_angle_table(dir_rows[i].val, 0, 1'b0);
        FILL_FLAT: load_angle_table(dir_rows[i].val, 0, 1'b1);
        default: begin
          push_beat(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].ang,
                    dir_rows[i].typed, dir_rows[i].res);
        end
      endcase
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      style  = p % 4;
      base   = (style == 0 && p == 0) ? '0 : ANGLE_W'($urandom);
      flat   = (style == 3);
      jitter = (style == 1) ? $urandom_range(1, 600) : (style == 2) ? 32767 : 0;
      load_angle_table(base, jitter, flat);
      for (int b = 0; b < PHASE_BEATS; b++) begin
        idx = ENTRY_INDEX_W'($urandom_range(0, TBL_N - 1));
        if ($urandom_range(0, 99) < 12) begin
          val = ($urandom_range(0, 7) == 0) ? ANGLE_W'($urandom)
                                            : shaped_entry(idx, base, jitter, flat);
          push_beat(OP_WRITE, idx, val, ANGLE_W'($urandom), 1'b0, '0);
        end else begin
          case ($urandom_range(0, 5))
            2:       ang = angle_shadow[idx];
            3:       ang = angle_shadow[idx] + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
            4:       ang = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: ang = ANGLE_W'($urandom);
          endcase
          push_beat(OP_LOOKUP, idx, ANGLE_W'($urandom), ang, 1'b0, '0);
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_encoder_angle_reverse_lookup: PASS");
    end else begin
      $display("tb_encoder_angle_reverse_lookup: FAIL");
    end
    $finish;
  end

endmodule
